// ----- src/dgpd_pkg.sv -----
// Shared widths, register indexes and alert codes of the dual grip presence detector.
package dgpd_pkg;

   localparam int SAMPLE_BITS  = 10;
   localparam int FRAC_BITS    = 8;
   localparam int FILT_BITS    = SAMPLE_BITS + FRAC_BITS;
   localparam int ALPHA_SHIFT  = 8;
   localparam int ALPHA_BITS   = ALPHA_SHIFT + 1;
   localparam int HYST_BITS    = 10;
   localparam int DEB_BITS     = 4;
   localparam int POL_BITS     = 2;
   localparam int LIMIT_BITS   = 18;
   localparam int ALERT_BITS   = 2;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DAT_BITS = 18;
   localparam int NUM_CH       = 2;

   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(1 << ALPHA_SHIFT);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FILTER_ALPHA    = 3'd0,
      CSR_GRIP_HYSTERESIS = 3'd1,
      CSR_LEFT_THRESHOLD  = 3'd2,
      CSR_RIGHT_THRESHOLD = 3'd3,
      CSR_POLARITY        = 3'd4,
      CSR_DEBOUNCE        = 3'd5,
      CSR_IMBALANCE       = 3'd6,
      CSR_SUDDEN_CHANGE   = 3'd7
   } csr_index_type;

   typedef enum logic [ALERT_BITS-1:0] {
      ALERT_HANDS_OFF = 2'd0,
      ALERT_NORMAL    = 2'd1,
      ALERT_WARNING   = 2'd2
   } alert_type;

   localparam logic [ALPHA_BITS-1:0]  RST_ALPHA     = 9'd64;
   localparam logic [HYST_BITS-1:0]   RST_HYST      = 10'd20;
   localparam logic [SAMPLE_BITS-1:0] RST_THRESHOLD = 10'd512;
   localparam logic [POL_BITS-1:0]    RST_POLARITY  = 2'd3;
   localparam logic [DEB_BITS-1:0]    RST_DEBOUNCE  = 4'd2;
   localparam logic [LIMIT_BITS-1:0]  RST_IMBALANCE = 18'd51200;
   localparam logic [LIMIT_BITS-1:0]  RST_SUDDEN    = 18'd25600;

endpackage

// ----- src/dgpd_if.sv -----
// Channel interfaces: sample requests, detector responses and register writes.
interface dgpd_req_if;
   import dgpd_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] left_sample;
   logic [SAMPLE_BITS-1:0] right_sample;
   modport source (output valid, left_sample, right_sample, input ready);
   modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface dgpd_rsp_if;
   import dgpd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ALERT_BITS-1:0] alert_code;
   logic                  left_contact;
   logic                  right_contact;
   logic [FILT_BITS-1:0]  left_smoothed;
   logic [FILT_BITS-1:0]  right_smoothed;
   logic [FILT_BITS-1:0]  side_difference;
   logic [FILT_BITS-1:0]  largest_change;
   modport source (output valid, alert_code, left_contact, right_contact, left_smoothed,
                   right_smoothed, side_difference, largest_change, input ready);
   modport sink   (input valid, alert_code, left_contact, right_contact, left_smoothed,
                   right_smoothed, side_difference, largest_change, output ready);
endinterface

interface dgpd_csr_if;
   import dgpd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CSR_DAT_BITS-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- src/dual_grip_presence_detector.sv -----
// Dual grip presence detector: EMA filters, hysteresis contact, debounce and alert.
// One sample pair is accepted every cycle while the response side keeps up. A transaction
// is held in the input register, where the filter multiply, contact decision and alert
// are formed in a single pass, and its response is loaded into the output register when
// that register is empty or its response is being taken. rsp valid is driven from the
// output register. The channel state (filters, contact, debounce counts) is updated as
// each transaction moves to the output register, so back-to-back samples see each other's
// results. While both registers hold a transaction, req ready follows rsp ready. Register
// writes are always accepted and take effect from the next cycle.
module dual_grip_presence_detector (
   input  logic clock,
   input  logic reset,
   dgpd_req_if.sink   req_bus,
   dgpd_rsp_if.source rsp_bus,
   dgpd_csr_if.sink   csr_bus
);
   import dgpd_pkg::*;

   localparam int PROD_BITS = FILT_BITS + ALPHA_BITS;

   logic [ALPHA_BITS-1:0]  alpha_ff;
   logic [HYST_BITS-1:0]   hyst_ff;
   logic [SAMPLE_BITS-1:0] thr_ff [NUM_CH];
   logic [POL_BITS-1:0]    pol_ff;
   logic [DEB_BITS-1:0]    deb_ff;
   logic [LIMIT_BITS-1:0]  imb_ff;
   logic [LIMIT_BITS-1:0]  sudden_ff;

   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] raw_ff [NUM_CH];
   logic                   out_valid_ff, out_valid_in;

   logic                   started_ff;
   logic [FILT_BITS-1:0]   filt_ff  [NUM_CH];
   logic [FILT_BITS-1:0]   filt_in  [NUM_CH];
   logic [NUM_CH-1:0]      held_ff, held_in;
   logic [DEB_BITS-1:0]    count_ff [NUM_CH];
   logic [DEB_BITS-1:0]    count_in [NUM_CH];

   logic [ALERT_BITS-1:0]  alert_ff, alert_in;
   logic [FILT_BITS-1:0]   diff_ff, diff_in;
   logic [FILT_BITS-1:0]   change_ff, change_in;

   logic                   req_fire;
   logic                   advance;
   logic [ALPHA_BITS-1:0]  alpha_sat;
   logic [ALPHA_BITS-1:0]  alpha_inv;
   logic [FILT_BITS-1:0]   step [NUM_CH];
   logic                   warn;

   assign req_fire       = req_bus.valid && req_bus.ready;
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !in_valid_ff || advance;
   assign csr_bus.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff   <= RST_ALPHA;
         hyst_ff    <= RST_HYST;
         thr_ff[0]  <= RST_THRESHOLD;
         thr_ff[1]  <= RST_THRESHOLD;
         pol_ff     <= RST_POLARITY;
         deb_ff     <= RST_DEBOUNCE;
         imb_ff     <= RST_IMBALANCE;
         sudden_ff  <= RST_SUDDEN;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_FILTER_ALPHA:    alpha_ff  <= csr_bus.wdata[ALPHA_BITS-1:0];
            CSR_GRIP_HYSTERESIS: hyst_ff   <= csr_bus.wdata[HYST_BITS-1:0];
            CSR_LEFT_THRESHOLD:  thr_ff[0] <= csr_bus.wdata[SAMPLE_BITS-1:0];
            CSR_RIGHT_THRESHOLD: thr_ff[1] <= csr_bus.wdata[SAMPLE_BITS-1:0];
            CSR_POLARITY:        pol_ff    <= csr_bus.wdata[POL_BITS-1:0];
            CSR_DEBOUNCE:        deb_ff    <= csr_bus.wdata[DEB_BITS-1:0];
            CSR_IMBALANCE:       imb_ff    <= csr_bus.wdata[LIMIT_BITS-1:0];
            CSR_SUDDEN_CHANGE:   sudden_ff <= csr_bus.wdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      alpha_sat = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
      alpha_inv = ALPHA_ONE - alpha_sat;
   end

   always_comb begin
      logic [FILT_BITS-1:0]   raw_fx;
      logic [FILT_BITS-1:0]   thr_fx;
      logic [PROD_BITS-1:0]   new_term;
      logic [PROD_BITS-1:0]   old_term;
      logic [PROD_BITS-1:0]   total;
      logic [FILT_BITS-1:0]   ema;
      logic [SAMPLE_BITS:0]   raw_up;
      logic [SAMPLE_BITS:0]   thr_up;
      logic                   high;
      logic                   hold_ok;
      logic                   entry_ok;
      logic                   present;
      logic [DEB_BITS-1:0]    next_count;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         raw_fx   = {raw_ff[ch], FRAC_BITS'(0)};
         thr_fx   = {thr_ff[ch], FRAC_BITS'(0)};
         new_term = PROD_BITS'(alpha_sat) * PROD_BITS'(raw_fx);
         old_term = PROD_BITS'(alpha_inv) * PROD_BITS'(filt_ff[ch]);
         total    = new_term + old_term;
         ema      = total[ALPHA_SHIFT +: FILT_BITS];
         high     = pol_ff[ch];
         raw_up   = (SAMPLE_BITS+1)'(raw_ff[ch]) + (SAMPLE_BITS+1)'(hyst_ff);
         thr_up   = (SAMPLE_BITS+1)'(thr_ff[ch]) + (SAMPLE_BITS+1)'(hyst_ff);
         hold_ok  = high ? (raw_up >= (SAMPLE_BITS+1)'(thr_ff[ch]))
                         : ((SAMPLE_BITS+1)'(raw_ff[ch]) <= thr_up);
         if (!started_ff || (held_ff[ch] && !hold_ok)) begin
            filt_in[ch] = raw_fx;
         end else begin
            filt_in[ch] = ema;
         end
         entry_ok = high ? (raw_ff[ch] >= thr_ff[ch] && filt_in[ch] >= thr_fx)
                         : (raw_ff[ch] <= thr_ff[ch] && filt_in[ch] <= thr_fx);
         present  = held_ff[ch] ? hold_ok : entry_ok;
         step[ch] = (filt_in[ch] > filt_ff[ch]) ? filt_in[ch] - filt_ff[ch]
                                                : filt_ff[ch] - filt_in[ch];
         next_count = (count_ff[ch] < deb_ff) ? count_ff[ch] + DEB_BITS'(1) : count_ff[ch];
         if (present) begin
            held_in[ch]  = 1'b1;
            count_in[ch] = '0;
         end else if (!held_ff[ch] || next_count >= deb_ff) begin
            held_in[ch]  = 1'b0;
            count_in[ch] = '0;
         end else begin
            held_in[ch]  = 1'b1;
            count_in[ch] = next_count;
         end
      end
   end

   always_comb begin
      diff_in   = (filt_in[0] > filt_in[1]) ? filt_in[0] - filt_in[1]
                                            : filt_in[1] - filt_in[0];
      if (!started_ff) begin
         change_in = '0;
      end else begin
         change_in = (step[0] > step[1]) ? step[0] : step[1];
      end
      warn = started_ff && (diff_in > imb_ff || change_in > sudden_ff);
      if (!(held_in[0] && held_in[1])) begin
         alert_in = ALERT_HANDS_OFF;
      end else if (warn) begin
         alert_in = ALERT_WARNING;
      end else begin
         alert_in = ALERT_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         held_ff      <= '0;
         count_ff[0]  <= '0;
         count_ff[1]  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            started_ff  <= 1'b1;
            held_ff     <= held_in;
            count_ff[0] <= count_in[0];
            count_ff[1] <= count_in[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         raw_ff[0] <= req_bus.left_sample;
         raw_ff[1] <= req_bus.right_sample;
      end
      if (advance) begin
         filt_ff[0] <= filt_in[0];
         filt_ff[1] <= filt_in[1];
         alert_ff   <= alert_in;
         diff_ff    <= diff_in;
         change_ff  <= change_in;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.alert_code      = alert_ff;
   assign rsp_bus.left_contact    = held_ff[0];
   assign rsp_bus.right_contact   = held_ff[1];
   assign rsp_bus.left_smoothed   = filt_ff[0];
   assign rsp_bus.right_smoothed  = filt_ff[1];
   assign rsp_bus.side_difference = diff_ff;
   assign rsp_bus.largest_change  = change_ff;

   warning_needs_both: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && alert_ff == ALERT_WARNING |-> held_ff[0] && held_ff[1])
      else $error("warning reported without contact on both sides");

   hands_off_matches_contact: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((alert_ff == ALERT_HANDS_OFF) == !(held_ff[0] && held_ff[1])))
      else $error("hands-off code disagrees with contact state");

   idle_before_first: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> held_ff == '0 && !out_valid_ff)
      else $error("contact or response present before first transaction");

   state_moves_with_response: assert property (@(posedge clock) disable iff (reset)
      $rose(started_ff) |-> out_valid_ff)
      else $error("first transaction left no response");

endmodule
